[design/lrp_pkg.sv]
// Shared types and constants for the root-path LIS max tree.
package lrp_pkg;

  localparam int RANK_W   = 10;
  localparam int LEN_W    = 11;
  localparam int STATUS_W = 2;

  localparam logic [LEN_W-1:0] LEN_MAX = 11'd2047;

  localparam logic REQ_ENTER = 1'b0;
  localparam logic REQ_LEAVE = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OVF = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_UNF = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_OLD,
    S_PMAX,
    S_POP,
    S_UPD0,
    S_UPD
  } state_t;

endpackage

[design/lis_root_path_max_tree.sv]
// Top level: sequencer over the max tree memory and the undo stack memory.
//
// After reset the block sweeps the max tree to zero, one entry a cycle, with
// busy high. A transaction is taken when start is high and busy is low. Its
// result shows on out_lis_length / out_status for exactly one cycle with
// out_valid high, and the receiver cannot hold it off. busy falls in that
// same cycle, so the next transaction can be taken at the edge that takes the
// result. Every cycle of the work is bounded by the single read port of the
// max tree memory. With power-of-two VALUES, from the accepting edge on:
// - An enter takes one leaf read, a prefix-max walk (one node read or one level
//   step a cycle), a leaf-to-root update and the result cycle.
// - A leave takes one stack read, the update and the result cycle.
// - An overflow or underflow runs a global-max walk and the result cycle.
// With power-of-two VALUES the root written last is the global maximum. For
// other VALUES a global-max walk over the tree levels follows the update.
module lis_root_path_max_tree #(
  parameter int VALUES    = 1024,
  parameter int MAX_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [lrp_pkg::RANK_W-1:0]  in_value_rank,
  output logic                        out_valid,
  output logic [lrp_pkg::LEN_W-1:0]   out_lis_length,
  output logic [lrp_pkg::STATUS_W-1:0] out_status
);

  import lrp_pkg::*;

  localparam int  RW    = $clog2(VALUES);
  localparam int  NW    = $clog2(2 * VALUES);
  localparam int  PW    = NW + 1;
  localparam int  SW    = $clog2(MAX_DEPTH);
  localparam int  DW    = $clog2(MAX_DEPTH + 1);
  localparam int  EW    = RW + LEN_W;
  localparam bit  POW2  = (VALUES & (VALUES - 1)) == 0;

  state_t              state_r, state_nxt;
  logic [NW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [DW-1:0]       depth_r, depth_nxt;
  logic [DW-1:0]       depth_m1;
  logic [RW-1:0]       rank_r, rank_nxt;
  logic [RW-1:0]       rank_c;
  logic [LEN_W-1:0]    old_r, old_nxt;
  logic [PW-1:0]       lo_r, lo_nxt;
  logic [PW-1:0]       up_r, up_nxt;
  logic [LEN_W-1:0]    best_r, best_nxt;
  logic [LEN_W-1:0]    best_f;
  logic [LEN_W-1:0]    cur_inc;
  logic [LEN_W-1:0]    new_leaf;
  logic                pend_r, pend_nxt;
  logic                gm_r, gm_nxt;
  logic [NW-1:0]       pos_r, pos_nxt;
  logic [NW-1:0]       pos_up;
  logic [LEN_W-1:0]    cur_r, cur_nxt;
  logic [LEN_W-1:0]    cur_up;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                t_we;
  logic [NW-1:0]       t_waddr;
  logic [LEN_W-1:0]    t_wdata;
  logic [NW-1:0]       t_raddr;
  logic [LEN_W-1:0]    t_rdata;

  logic                s_we;
  logic [SW-1:0]       s_waddr;
  logic [EW-1:0]       s_wdata;
  logic [SW-1:0]       s_raddr;
  logic [EW-1:0]       s_rdata;

  lrp_ram #(.WIDTH(LEN_W), .DEPTH(2 * VALUES)) u_tree (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  lrp_ram #(.WIDTH(EW), .DEPTH(MAX_DEPTH)) u_undo (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_lis_length = out_len_r;
  assign out_status     = status_r;

  assign rank_c   = (int'(in_value_rank) >= VALUES) ? RW'(VALUES - 1) : RW'(in_value_rank);
  assign depth_m1 = depth_r - DW'(1);
  assign best_f   = (pend_r && (t_rdata > best_r)) ? t_rdata : best_r;
  assign cur_inc  = (best_f == LEN_MAX) ? best_f : best_f + LEN_W'(1);
  assign new_leaf = (old_r > cur_inc) ? old_r : cur_inc;
  assign pos_up   = pos_r >> 1;
  assign cur_up   = (t_rdata > cur_r) ? t_rdata : cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      depth_r     <= '0;
      pend_r      <= 1'b0;
      gm_r        <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= STAT_OK;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      depth_r     <= depth_nxt;
      pend_r      <= pend_nxt;
      gm_r        <= gm_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r    <= rank_nxt;
    old_r     <= old_nxt;
    lo_r      <= lo_nxt;
    up_r      <= up_nxt;
    best_r    <= best_nxt;
    pos_r     <= pos_nxt;
    cur_r     <= cur_nxt;
    out_len_r <= out_len_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    depth_nxt     = depth_r;
    rank_nxt      = rank_r;
    old_nxt       = old_r;
    lo_nxt        = lo_r;
    up_nxt        = up_r;
    best_nxt      = best_r;
    pend_nxt      = 1'b0;
    gm_nxt        = gm_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    status_nxt    = status_r;
    out_len_nxt   = out_len_r;
    out_valid_nxt = 1'b0;
    t_we          = 1'b0;
    t_waddr       = pos_r;
    t_wdata       = cur_r;
    t_raddr       = '0;
    s_we          = 1'b0;
    s_waddr       = depth_r[SW-1:0];
    s_wdata       = {rank_r, old_r};
    s_raddr       = depth_m1[SW-1:0];

    case (state_r)
      S_CLEAR: begin
        t_we        = 1'b1;
        t_waddr     = clr_cnt_r;
        t_wdata     = '0;
        clr_cnt_nxt = clr_cnt_r + NW'(1);
        if (clr_cnt_r == NW'(2 * VALUES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          rank_nxt   = rank_c;
          status_nxt = STAT_OK;
          lo_nxt     = PW'(VALUES);
          up_nxt     = PW'(2 * VALUES);
          best_nxt   = '0;
          gm_nxt     = 1'b1;
          if (in_req_type == REQ_ENTER) begin
            if (depth_r == DW'(MAX_DEPTH)) begin
              status_nxt = STAT_OVF;
              state_nxt  = S_PMAX;
            end else begin
              t_raddr   = NW'(VALUES) + NW'(rank_c);
              state_nxt = S_OLD;
            end
          end else begin
            if (depth_r == '0) begin
              status_nxt = STAT_UNF;
              state_nxt  = S_PMAX;
            end else begin
              depth_nxt = depth_m1;
              state_nxt = S_POP;
            end
          end
        end
      end

      S_OLD: begin
        old_nxt   = t_rdata;
        lo_nxt    = PW'(VALUES);
        up_nxt    = PW'(VALUES) + PW'(rank_r);
        best_nxt  = '0;
        gm_nxt    = 1'b0;
        state_nxt = S_PMAX;
      end

      S_PMAX: begin
        best_nxt = best_f;
        if (lo_r < up_r) begin
          if (lo_r[0]) begin
            t_raddr  = lo_r[NW-1:0];
            lo_nxt   = lo_r + PW'(1);
            pend_nxt = 1'b1;
          end else if (up_r[0]) begin
            t_raddr  = NW'(up_r - PW'(1));
            up_nxt   = up_r - PW'(1);
            pend_nxt = 1'b1;
          end else begin
            lo_nxt = lo_r >> 1;
            up_nxt = up_r >> 1;
          end
        end else if (gm_r) begin
          out_len_nxt   = best_f;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          s_we      = 1'b1;
          depth_nxt = depth_r + DW'(1);
          pos_nxt   = NW'(VALUES) + NW'(rank_r);
          cur_nxt   = new_leaf;
          state_nxt = S_UPD0;
        end
      end

      S_POP: begin
        pos_nxt   = NW'(VALUES) + NW'(s_rdata[LEN_W +: RW]);
        cur_nxt   = s_rdata[LEN_W-1:0];
        state_nxt = S_UPD0;
      end

      S_UPD0: begin
        t_we      = 1'b1;
        t_raddr   = pos_r ^ NW'(1);
        state_nxt = S_UPD;
      end

      S_UPD: begin
        t_we    = 1'b1;
        t_waddr = pos_up;
        t_wdata = cur_up;
        t_raddr = pos_up ^ NW'(1);
        pos_nxt = pos_up;
        cur_nxt = cur_up;
        if (pos_up == NW'(1)) begin
          if (POW2) begin
            out_len_nxt   = cur_up;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            lo_nxt    = PW'(VALUES);
            up_nxt    = PW'(2 * VALUES);
            best_nxt  = '0;
            gm_nxt    = 1'b1;
            state_nxt = S_PMAX;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_DEPTH))
    else $error("undo stack depth beyond its size");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_OVF)) |-> (depth_r == DW'(MAX_DEPTH)))
    else $error("overflow reported with room on the stack");

  a_unf_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_UNF)) |-> (depth_r == '0))
    else $error("underflow reported with entries on the stack");

endmodule

[design/lrp_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
module lrp_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 2048,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[tb/lis_root_path_max_tree_tb.sv]
// Self-checking bench for root-path LIS max tree: directed table, random path walks, overflow.
`timescale 1ns / 100ps

module lis_root_path_max_tree_tb;
  import lrp_pkg::*;

  localparam int VALUE_COUNT = 1024;
  localparam int STACK_DEPTH = 1024;

  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [STATUS_W-1:0] status;
  } lis_result_t;

  typedef struct {
    logic              req;
    logic [RANK_W-1:0] rank;
    bit                typed;
    lis_result_t       want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_req_type;
  logic [RANK_W-1:0]   in_value_rank;
  logic                out_valid;
  logic [LEN_W-1:0]    out_lis_length;
  logic [STATUS_W-1:0] out_status;

  lis_root_path_max_tree #(
    .VALUES   (VALUE_COUNT),
    .MAX_DEPTH(STACK_DEPTH)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_value_rank (in_value_rank),
    .out_valid     (out_valid),
    .out_lis_length(out_lis_length),
    .out_status    (out_status)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [LEN_W-1:0]  leaf_len   [0:VALUE_COUNT-1];
  logic [RANK_W-1:0] saved_rank [0:STACK_DEPTH-1];
  logic [LEN_W-1:0]  saved_len  [0:STACK_DEPTH-1];
  int                path_depth;

  lis_result_t pending_results[$];
  stim_row_t   stim_rows[$];
  int          mismatch_count;
  int          enter_count, leave_count, ovf_count, unf_count, peak_depth, peak_len;
  bit          steady;

  function automatic lis_result_t lis_apply(input logic req, input logic [RANK_W-1:0] rank);
    lis_result_t      r;
    logic [LEN_W-1:0] below;
    logic [LEN_W:0]   cand;
    r.status = STAT_OK;
    if (req == REQ_ENTER) begin
      if (path_depth >= STACK_DEPTH) begin
        r.status = STAT_OVF;
      end else begin
        below = '0;
        for (int i = 0; i < int'(rank); i++)
          if (leaf_len[i] > below) below = leaf_len[i];
        cand = {1'b0, below} + 1'b1;
        if (cand > {1'b0, LEN_MAX}) cand = {1'b0, LEN_MAX};
        saved_rank[path_depth] = rank;
        saved_len[path_depth]  = leaf_len[rank];
        path_depth++;
        if (cand[LEN_W-1:0] > leaf_len[rank]) leaf_len[rank] = cand[LEN_W-1:0];
      end
    end else begin
      if (path_depth == 0) begin
        r.status = STAT_UNF;
      end else begin
        path_depth--;
        leaf_len[saved_rank[path_depth]] = saved_len[path_depth];
      end
    end
    r.len = '0;
    for (int i = 0; i < VALUE_COUNT; i++)
      if (leaf_len[i] > r.len) r.len = leaf_len[i];
    return r;
  endfunction

  task automatic add_row(input logic req, input logic [RANK_W-1:0] rank, input bit typed,
                         input logic [LEN_W-1:0] len, input logic [STATUS_W-1:0] st);
    stim_row_t row;
    row.req   = req;
    row.rank  = rank;
    row.typed = typed;
    row.want  = {len, st};
    stim_rows = {stim_rows, row};
  endtask

  task automatic send_txn(input logic req, input logic [RANK_W-1:0] rank, input bit typed,
                          input lis_result_t want);
    lis_result_t predicted;
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 50)) @(negedge clk);
    end
    start         <= 1'b1;
    in_req_type   <= req;
    in_value_rank <= rank;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = lis_apply(req, rank);
    pending_results = {pending_results, (typed ? want : predicted)};
    if (req == REQ_ENTER) enter_count++;
    else leave_count++;
    if (predicted.status == STAT_OVF) ovf_count++;
    if (predicted.status == STAT_UNF) unf_count++;
    if (path_depth > peak_depth) peak_depth = path_depth;
    if (int'(predicted.len) > peak_len) peak_len = int'(predicted.len);
  endtask

  // result checker
  always @(posedge clk) begin
    lis_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: lis_length %0d status %0d", $time,
                 out_lis_length, out_status);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_lis_length !== exp_r.len) begin
          $display("%0t: lis_length mismatch: expected %0d, actual %0d", $time,
                   exp_r.len, out_lis_length);
          mismatch_count++;
        end
        if (out_status !== exp_r.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                   exp_r.status, out_status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic              req;
    logic [RANK_W-1:0] rank;
    int                pick;
    foreach (leaf_len[i]) leaf_len[i] = '0;
    path_depth     = 0;
    mismatch_count = 0;
    enter_count    = 0;
    leave_count    = 0;
    ovf_count      = 0;
    unf_count      = 0;
    peak_depth     = 0;
    peak_len       = 0;
    steady         = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_req_type    = REQ_ENTER;
    in_value_rank  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed table: underflow, extremes, repeated ranks on one path
    add_row(REQ_LEAVE, 10'd0,    1, 11'd0, STAT_UNF);
    add_row(REQ_ENTER, 10'd0,    1, 11'd1, STAT_OK);
    add_row(REQ_LEAVE, 10'd0,    1, 11'd0, STAT_OK);
    add_row(REQ_ENTER, 10'd1023, 1, 11'd1, STAT_OK);
    add_row(REQ_ENTER, 10'd0,    0, 11'd0, STAT_OK);
    add_row(REQ_ENTER, 10'd512,  0, 11'd0, STAT_OK);
    add_row(REQ_ENTER, 10'd1023, 0, 11'd0, STAT_OK);
    add_row(REQ_ENTER, 10'd1023, 0, 11'd0, STAT_OK);
    repeat (5) add_row(REQ_LEAVE, 10'd1023, 0, 11'd0, STAT_OK);
    add_row(REQ_ENTER, 10'h155,  0, 11'd0, STAT_OK);
    add_row(REQ_ENTER, 10'h2AA,  0, 11'd0, STAT_OK);
    add_row(REQ_ENTER, 10'd1,    0, 11'd0, STAT_OK);
    add_row(REQ_ENTER, 10'd1022, 0, 11'd0, STAT_OK);
    add_row(REQ_ENTER, 10'd1022, 0, 11'd0, STAT_OK);
    repeat (5) add_row(REQ_LEAVE, 10'h3FF, 0, 11'd0, STAT_OK);
    add_row(REQ_LEAVE, 10'h2AA,  0, 11'd0, STAT_UNF);
    foreach (stim_rows[i])
      send_txn(stim_rows[i].req, stim_rows[i].rank, stim_rows[i].typed, stim_rows[i].want);

    // random depth-first walks
    for (int n = 0; n < 900; n++) begin
      steady = (n >= 350 && n < 650);
      if (path_depth == 0)
        req = ($urandom_range(0, 9) == 0) ? REQ_LEAVE : REQ_ENTER;
      else if (path_depth < 40)
        req = ($urandom_range(0, 99) < 55) ? REQ_ENTER : REQ_LEAVE;
      else
        req = ($urandom_range(0, 99) < 30) ? REQ_ENTER : REQ_LEAVE;
      pick = $urandom_range(0, 3);
      case (pick)
        0, 1: rank = RANK_W'($urandom_range(0, 1023));
        2: rank = RANK_W'($urandom_range(0, 31));
        default: rank = RANK_W'($urandom_range(992, 1023));
      endcase
      send_txn(req, rank, 0, '0);
    end
    steady = 1'b0;
    while (path_depth != 0) send_txn(REQ_LEAVE, RANK_W'($urandom_range(0, 1023)), 0, '0);

    // fill the undo stack along one ascending path, overflow it, then back off part way
    for (int i = 0; i < STACK_DEPTH; i++) send_txn(REQ_ENTER, i[RANK_W-1:0], 0, '0);
    send_txn(REQ_ENTER, 10'd0, 0, '0);
    repeat (3) send_txn(REQ_ENTER, RANK_W'($urandom_range(0, 1023)), 0, '0);
    repeat (32) send_txn(REQ_LEAVE, RANK_W'($urandom_range(0, 1023)), 0, '0);

    @(negedge clk);
    start <= 1'b0;
    for (int w = 0; w < 20000 && pending_results.size() != 0; w++) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      mismatch_count++;
    end
    repeat (200) @(posedge clk);

    $display("Ran %0d enter and %0d leave transactions; %0d overflow, %0d underflow returns.",
             enter_count, leave_count, ovf_count, unf_count);
    $display("Deepest path %0d nodes, longest subsequence %0d.", peak_depth, peak_len);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
design/lrp_pkg.sv
design/lrp_ram.sv
design/lis_root_path_max_tree.sv
tb/lis_root_path_max_tree_tb.sv
